[design/php_pkg.sv]
`default_nettype none

package php_pkg;

  // Frame layout
  localparam logic [15:0] POS_MAX       = 16'hFFFF;
  localparam logic [15:0] ET_POS_HI     = 16'd12;
  localparam logic [15:0] ET_POS_LO     = 16'd13;
  localparam logic [15:0] VLAN_ET_HI    = 16'd16;
  localparam logic [15:0] VLAN_ET_LO    = 16'd17;
  localparam logic [4:0]  L3_START_ETH  = 5'd14;
  localparam logic [4:0]  L3_START_VLAN = 5'd18;
  localparam logic [7:0]  NEED_ETH      = 8'd14;
  localparam logic [7:0]  NEED_VLAN     = 8'd18;
  localparam logic [7:0]  IPV4_MIN_HDR  = 8'd20;
  localparam logic [6:0]  IPV6_HDR_LEN  = 7'd40;
  localparam logic [15:0] IPV4_PROTO_OFS = 16'd9;
  localparam logic [15:0] IPV6_NH_OFS   = 16'd6;
  localparam logic [15:0] TCP_DOFF_OFS  = 16'd12;
  localparam logic [7:0]  TCP_DOFF_NEED = 8'd13;
  localparam logic [7:0]  UDP_HDR_LEN   = 8'd8;
  localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
  localparam logic [3:0]  IPV4_VERSION  = 4'd4;
  localparam logic [3:0]  IPV6_VERSION  = 4'd6;

  // Ethertypes and protocol numbers
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // Application signatures
  localparam logic [31:0] HTTP_GET  = 32'h47455420;
  localparam logic [31:0] HTTP_POST = 32'h504F5354;
  localparam logic [31:0] HTTP_PUT  = 32'h50555420;
  localparam logic [31:0] HTTP_HEAD = 32'h48454144;
  localparam logic [7:0]  TLS_HANDSHAKE = 8'h16;
  localparam logic [7:0]  TLS_MAJOR     = 8'h03;

  typedef enum logic [2:0] {
    CLS_UNKNOWN = 3'd0,
    CLS_IPV4    = 3'd1,
    CLS_IPV6    = 3'd2,
    CLS_TCP     = 3'd3,
    CLS_UDP     = 3'd4,
    CLS_VLAN    = 3'd5,
    CLS_HTTP    = 3'd6,
    CLS_TLS     = 3'd7
  } php_class_t;

  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] et;
    logic        vlan;
    logic        ipv4;
    logic        ipv6;
    logic        tcp;
    logic        udp;
    logic [4:0]  l3_start;
    logic [6:0]  l4_start;
    logic [7:0]  proto;
    logic [5:0]  l4_len;
    logic [7:0]  pay_start;
    logic [31:0] pay_head;
    logic        malformed;
    logic        k_l4pos;
    logic        k_proto;
    logic        k_l4len;
    logic        k_pay;
  } php_state_t;

  localparam php_state_t PHP_STATE_RST = '{l3_start: L3_START_ETH, default: '0};

  typedef struct packed {
    php_class_t  pkt_class;
    logic        vlan_seen;
    logic        ipv4_seen;
    logic        ipv6_seen;
    logic        tcp_seen;
    logic        udp_seen;
    logic [7:0]  l3_protocol;
    logic [5:0]  l4_header_len;
    logic [15:0] payload_offset;
    logic [15:0] payload_len;
    logic        header_ok;
  } php_result_t;

endpackage

`default_nettype wire

[design/php_parse.sv]
`default_nettype none

module php_parse (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output php_pkg::php_state_t    st_nxt,
  output logic [15:0]            cur_pos
);
  import php_pkg::*;

  php_state_t st_r;

  function automatic php_state_t take_proto(input php_state_t st, input logic [7:0] b);
    php_state_t r;
    r = st;
    r.proto = b;
    r.k_proto = 1'b1;
    if (b == PROTO_TCP) begin
      r.tcp = 1'b1;
    end else if (b == PROTO_UDP) begin
      r.udp = 1'b1;
    end
    if (r.k_l4pos && b != PROTO_TCP) begin
      r.l4_len = (b == PROTO_UDP || b == PROTO_ICMP) ? 6'(UDP_HDR_LEN) : 6'd0;
      r.k_l4len = 1'b1;
      if (b == PROTO_UDP) begin
        r.pay_start = 8'(r.l4_start) + UDP_HDR_LEN;
        r.k_pay = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    php_state_t s;
    logic [3:0] lo_nib;
    logic [3:0] hi_nib;
    s = st_r;
    lo_nib = data_byte[3:0];
    hi_nib = data_byte[7:4];

    // shift in the outer or the tagged ethertype
    if (s.pos == ET_POS_HI || s.pos == ET_POS_LO ||
        (s.vlan && (s.pos == VLAN_ET_HI || s.pos == VLAN_ET_LO))) begin
      s.et = {s.et[7:0], data_byte};
    end
    if (s.pos == ET_POS_LO) begin
      if (s.et == ETYPE_VLAN) begin
        s.vlan = 1'b1;
        s.l3_start = L3_START_VLAN;
      end else if (s.et == ETYPE_IPV4) begin
        s.ipv4 = 1'b1;
      end else if (s.et == ETYPE_IPV6) begin
        s.ipv6 = 1'b1;
      end
    end else if (s.pos == VLAN_ET_LO && s.vlan) begin
      if (s.et == ETYPE_IPV4) begin
        s.ipv4 = 1'b1;
      end else if (s.et == ETYPE_IPV6) begin
        s.ipv6 = 1'b1;
      end
    end

    if (s.ipv4) begin
      if (s.pos == 16'(s.l3_start)) begin
        if (hi_nib != IPV4_VERSION) s.malformed = 1'b1;
        if (lo_nib < MIN_HDR_WORDS) begin
          s.malformed = 1'b1;
        end else begin
          s.l4_start = 7'(s.l3_start) + {1'b0, lo_nib, 2'b00};
          s.k_l4pos = 1'b1;
        end
      end else if (s.pos == 16'(s.l3_start) + IPV4_PROTO_OFS) begin
        s = take_proto(s, data_byte);
      end
    end else if (s.ipv6) begin
      if (s.pos == 16'(s.l3_start)) begin
        if (hi_nib != IPV6_VERSION) s.malformed = 1'b1;
        s.l4_start = 7'(s.l3_start) + IPV6_HDR_LEN;
        s.k_l4pos = 1'b1;
      end else if (s.pos == 16'(s.l3_start) + IPV6_NH_OFS) begin
        s = take_proto(s, data_byte);
      end
    end

    // TCP data offset
    if (s.tcp && s.k_l4pos && s.pos == 16'(s.l4_start) + TCP_DOFF_OFS) begin
      s.l4_len = {hi_nib, 2'b00};
      s.k_l4len = 1'b1;
      if (hi_nib < MIN_HDR_WORDS) begin
        s.malformed = 1'b1;
      end else begin
        s.pay_start = 8'(s.l4_start) + {2'b00, hi_nib, 2'b00};
        s.k_pay = 1'b1;
      end
    end

    // capture up to four leading payload bytes
    if (s.k_pay && s.pos >= 16'(s.pay_start) &&
        {1'b0, s.pos} < 17'(s.pay_start) + 17'd4) begin
      s.pay_head = {s.pay_head[23:0], data_byte};
    end

    if (s.pos == POS_MAX) begin
      s.malformed = 1'b1;
    end else begin
      s.pos = s.pos + 16'd1;
    end

    st_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PHP_STATE_RST;
    end else if (adv) begin
      st_r <= last_byte ? PHP_STATE_RST : st_nxt;
    end
  end

  assign cur_pos = st_r.pos;

endmodule

`default_nettype wire

[design/php_report.sv]
`default_nettype none

module php_report (
  input  wire logic [15:0]         cur_pos,
  input  wire php_pkg::php_state_t st,
  output php_pkg::php_result_t     res
);
  import php_pkg::*;

  always_comb begin
    logic [15:0] flen;
    logic [7:0]  need;
    logic [5:0]  l4h;
    logic        trunc;
    logic [15:0] poff;
    logic [15:0] plen;
    logic        http;
    logic        tls;
    php_class_t  cls;

    flen = (cur_pos == POS_MAX) ? POS_MAX : cur_pos + 16'd1;

    // bytes the announced headers require
    need = st.vlan ? NEED_VLAN : NEED_ETH;
    l4h = 6'd0;
    if (st.ipv4) need = 8'(st.l3_start) + IPV4_MIN_HDR;
    if ((st.ipv4 || st.ipv6) && st.k_l4pos) begin
      if (8'(st.l4_start) > need) need = 8'(st.l4_start);
      if (st.k_proto) begin
        if (st.proto == PROTO_TCP) begin
          need = st.k_pay ? st.pay_start : 8'(st.l4_start) + TCP_DOFF_NEED;
        end else if (st.proto == PROTO_UDP || st.proto == PROTO_ICMP) begin
          need = 8'(st.l4_start) + UDP_HDR_LEN;
        end
      end
      if (st.k_l4len) l4h = st.l4_len;
    end
    trunc = flen < 16'(need);

    poff = 16'd0;
    plen = 16'd0;
    http = 1'b0;
    tls  = 1'b0;
    if (st.k_pay && 16'(st.pay_start) < flen) begin
      poff = 16'(st.pay_start);
      plen = flen - poff;
      if (plen >= 16'd4) begin
        http = st.pay_head == HTTP_GET || st.pay_head == HTTP_POST ||
               st.pay_head == HTTP_PUT || st.pay_head == HTTP_HEAD;
        tls  = st.pay_head[31:24] == TLS_HANDSHAKE && st.pay_head[23:16] == TLS_MAJOR;
      end else if (plen == 16'd3) begin
        tls  = st.pay_head[23:16] == TLS_HANDSHAKE && st.pay_head[15:8] == TLS_MAJOR;
      end
    end

    // later layers override earlier ones
    cls = CLS_UNKNOWN;
    if (st.ipv4) begin
      cls = CLS_IPV4;
    end else if (st.ipv6) begin
      cls = CLS_IPV6;
    end
    if (st.tcp) begin
      cls = CLS_TCP;
    end else if (st.udp) begin
      cls = CLS_UDP;
    end
    if (st.vlan) cls = CLS_VLAN;
    if (http) begin
      cls = CLS_HTTP;
    end else if (tls) begin
      cls = CLS_TLS;
    end

    res.pkt_class      = cls;
    res.vlan_seen      = st.vlan;
    res.ipv4_seen      = st.ipv4;
    res.ipv6_seen      = st.ipv6;
    res.tcp_seen       = st.tcp;
    res.udp_seen       = st.udp;
    res.l3_protocol    = st.proto;
    res.l4_header_len  = l4h;
    res.payload_offset = poff;
    res.payload_len    = plen;
    res.header_ok      = !(st.malformed || trunc);
  end

endmodule

`default_nettype wire

[design/packet_header_parser_classifier.sv]
`default_nettype none

// Frame header parser and classifier. Feed a frame one word (byte) per clock,
// starting at the destination MAC, with in_last_byte on its final byte; the
// block takes one word every cycle except during the stall described below and
// emits exactly one result word per frame, registered once the last byte
// leaves the input register (it stays there while an earlier result still waits
// at the output), carrying the class (unknown, IPv6, IPv4, UDP, TCP, VLAN, TLS,
// HTTP in rising priority), the layer flags, the L3 protocol, the L4 header
// length, payload offset and length, and a header check that drops to 0 on a
// bad IP version, IHL or TCP data offset below five, a frame shorter than its
// announced headers, or a frame of 64 KiB or more. The rate is set by the parser
// state update, which is combinational and sits between the input register and
// the result register. Input stalls only while a finished result waits at the
// output and the byte in the input register is itself a last byte.
module packet_header_parser_classifier (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_pkt_class,
  output logic             out_vlan_seen,
  output logic             out_ipv4_seen,
  output logic             out_ipv6_seen,
  output logic             out_tcp_seen,
  output logic             out_udp_seen,
  output logic [7:0]       out_l3_protocol,
  output logic [5:0]       out_l4_header_len,
  output logic [15:0]      out_payload_offset,
  output logic [15:0]      out_payload_len,
  output logic             out_header_ok
);
  import php_pkg::*;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_go;

  // result register
  logic        out_valid_r;
  php_result_t res_r;

  php_state_t  st_nxt;
  logic [15:0] cur_pos;
  php_result_t res_nxt;

  // Advance the held word unless it closes a frame and the result slot is
  // still occupied.
  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  php_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_go),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .st_nxt    (st_nxt),
    .cur_pos   (cur_pos)
  );

  php_report u_report (
    .cur_pos (cur_pos),
    .st      (st_nxt),
    .res     (res_nxt)
  );

  // Load a result on the last word, drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pkt_class      = res_r.pkt_class;
  assign out_vlan_seen      = res_r.vlan_seen;
  assign out_ipv4_seen      = res_r.ipv4_seen;
  assign out_ipv6_seen      = res_r.ipv6_seen;
  assign out_tcp_seen       = res_r.tcp_seen;
  assign out_udp_seen       = res_r.udp_seen;
  assign out_l3_protocol    = res_r.l3_protocol;
  assign out_l4_header_len  = res_r.l4_header_len;
  assign out_payload_offset = res_r.payload_offset;
  assign out_payload_len    = res_r.payload_len;
  assign out_header_ok      = res_r.header_ok;

`ifndef SYNTHESIS
  a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> out_valid_r)
    else $error("last word did not produce a result");

  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> cur_pos == 16'd0)
    else $error("parser position not cleared after frame end");

  a_blocked_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && out_valid_r && !out_ready |=> s1_valid_r && s1_last_r)
    else $error("last word advanced while the result slot was full");

  a_tcp_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.pkt_class == CLS_TCP |-> res_r.tcp_seen && !res_r.vlan_seen)
    else $error("TCP class without TCP flag or with VLAN");

  a_payload_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.payload_len != 16'd0 |-> res_r.payload_offset != 16'd0)
    else $error("payload length without payload offset");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import php_pkg::*;

  localparam int PERIOD         = 20;
  localparam int QUIET_LIMIT    = 4000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES   = 8;
  localparam int IPV4_BASE_HDR  = 20;
  localparam int IPV6_BASE_HDR  = 40;
  localparam int TCP_BASE_HDR   = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_pkt_class;
  logic        out_vlan_seen;
  logic        out_ipv4_seen;
  logic        out_ipv6_seen;
  logic        out_tcp_seen;
  logic        out_udp_seen;
  logic [7:0]  out_l3_protocol;
  logic [5:0]  out_l4_header_len;
  logic [15:0] out_payload_offset;
  logic [15:0] out_payload_len;
  logic        out_header_ok;

  packet_header_parser_classifier dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pkt_class      (out_pkt_class),
    .out_vlan_seen      (out_vlan_seen),
    .out_ipv4_seen      (out_ipv4_seen),
    .out_ipv6_seen      (out_ipv6_seen),
    .out_tcp_seen       (out_tcp_seen),
    .out_udp_seen       (out_udp_seen),
    .out_l3_protocol    (out_l3_protocol),
    .out_l4_header_len  (out_l4_header_len),
    .out_payload_offset (out_payload_offset),
    .out_payload_len    (out_payload_len),
    .out_header_ok      (out_header_ok)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Knobs for the current idling phase, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int words_sent     = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  // Frame reports still owed by the block, oldest first.
  php_result_t pending_reports[$];

  // Shadow of the parser: position in the frame, ethertype shifter, layer flags,
  // header offsets and the first four payload bytes, plus "known" bits that say
  // which of those fields have actually been seen in this frame.
  logic [15:0] pos_q;
  logic [15:0] etype_sr;
  logic        vlan_tag_seen, has_v4, has_v6, has_tcp, has_udp;
  int          l3_base;
  int          l4_base;
  logic [7:0]  proto_q;
  logic [5:0]  l4_len_q;
  int          pay_base;
  logic [31:0] head_sr;
  logic        bad_hdr;
  logic        k_l4pos, k_proto, k_l4len, k_pay;

  task automatic clear_parse_state();
    pos_q    = '0;
    etype_sr = '0;
    {vlan_tag_seen, has_v4, has_v6, has_tcp, has_udp} = '0;
    l3_base  = L3_START_ETH;
    l4_base  = 0;
    proto_q  = '0;
    l4_len_q = '0;
    pay_base = 0;
    head_sr  = '0;
    bad_hdr  = 1'b0;
    {k_l4pos, k_proto, k_l4len, k_pay} = '0;
  endtask

  task automatic note_etype(input logic [15:0] et);
    if (et == ETYPE_IPV4) has_v4 = 1'b1;
    else if (et == ETYPE_IPV6) has_v6 = 1'b1;
  endtask

  // The protocol byte fixes the L4 length for UDP and ICMP right away, and the
  // payload start for UDP; TCP has to wait for its data offset.
  task automatic note_proto(input logic [7:0] b);
    proto_q = b;
    k_proto = 1'b1;
    if (b == PROTO_TCP) has_tcp = 1'b1;
    else if (b == PROTO_UDP) has_udp = 1'b1;
    if (!k_l4pos || b == PROTO_TCP) return;
    l4_len_q = (b == PROTO_UDP || b == PROTO_ICMP) ? 6'd8 : 6'd0;
    k_l4len = 1'b1;
    if (b == PROTO_UDP) begin
      pay_base = l4_base + 8;
      k_pay = 1'b1;
    end
  endtask

  // Advance the shadow parser by one accepted word; on the last word of a
  // frame, queue the report the block owes and start over.
  task automatic track_header_byte(input logic [7:0] b, input logic is_last);
    int          p;
    int          flen, need, poff, plen, n, ihl, doff;
    logic [5:0]  l4h;
    logic        http, tls, trunc;
    php_class_t  cls;
    php_result_t rep;
    p = pos_q;
    if (p == 12 || p == 13 || (vlan_tag_seen && (p == 16 || p == 17)))
      etype_sr = {etype_sr[7:0], b};
    if (p == 13) begin
      if (etype_sr == ETYPE_VLAN) begin
        vlan_tag_seen = 1'b1;
        l3_base = L3_START_VLAN;
      end else begin
        note_etype(etype_sr);
      end
    end else if (p == 17 && vlan_tag_seen) begin
      note_etype(etype_sr);
    end

    if (has_v4) begin
      if (p == l3_base) begin
        ihl = b[3:0];
        if (b[7:4] != IPV4_VERSION) bad_hdr = 1'b1;
        if (ihl < MIN_HDR_WORDS) begin
          bad_hdr = 1'b1;
        end else begin
          l4_base = l3_base + ihl * 4;
          k_l4pos = 1'b1;
        end
      end else if (p == l3_base + IPV4_PROTO_OFS) begin
        note_proto(b);
      end
    end else if (has_v6) begin
      if (p == l3_base) begin
        if (b[7:4] != IPV6_VERSION) bad_hdr = 1'b1;
        l4_base = l3_base + IPV6_BASE_HDR;
        k_l4pos = 1'b1;
      end else if (p == l3_base + IPV6_NH_OFS) begin
        note_proto(b);
      end
    end

    if (has_tcp && k_l4pos && p == l4_base + TCP_DOFF_OFS) begin
      doff = b[7:4];
      l4_len_q = 6'(doff * 4);
      k_l4len = 1'b1;
      if (doff < MIN_HDR_WORDS) begin
        bad_hdr = 1'b1;
      end else begin
        pay_base = l4_base + doff * 4;
        k_pay = 1'b1;
      end
    end

    if (k_pay && p >= pay_base && p < pay_base + 4) head_sr = {head_sr[23:0], b};

    // Saturate the position once the frame reaches 64 KiB.
    if (p == POS_MAX) bad_hdr = 1'b1;
    else pos_q = 16'(p + 1);

    if (!is_last) return;

    flen = (p == POS_MAX) ? POS_MAX : p + 1;
    need = vlan_tag_seen ? NEED_VLAN : NEED_ETH;
    if (has_v4) need = l3_base + IPV4_BASE_HDR;
    l4h = '0;
    if ((has_v4 || has_v6) && k_l4pos) begin
      if (l4_base > need) need = l4_base;
      if (k_proto) begin
        if (proto_q == PROTO_TCP) need = k_pay ? pay_base : l4_base + TCP_DOFF_NEED;
        else if (proto_q == PROTO_UDP || proto_q == PROTO_ICMP) need = l4_base + 8;
      end
      if (k_l4len) l4h = l4_len_q;
    end
    trunc = flen < need;

    http = 1'b0;
    tls  = 1'b0;
    poff = 0;
    plen = 0;
    if (k_pay && pay_base < flen) begin
      poff = pay_base;
      plen = flen - poff;
      n = (plen < 4) ? plen : 4;
      if (n == 4 && (head_sr == HTTP_GET || head_sr == HTTP_POST ||
                     head_sr == HTTP_PUT || head_sr == HTTP_HEAD))
        http = 1'b1;
      if (n >= 3 && 8'(head_sr >> (8 * (n - 1))) == TLS_HANDSHAKE &&
          8'(head_sr >> (8 * (n - 2))) == TLS_MAJOR)
        tls = 1'b1;
    end

    // Later rules override earlier ones.
    cls = CLS_UNKNOWN;
    if (has_v4) cls = CLS_IPV4;
    else if (has_v6) cls = CLS_IPV6;
    if (has_tcp) cls = CLS_TCP;
    else if (has_udp) cls = CLS_UDP;
    if (vlan_tag_seen) cls = CLS_VLAN;
    if (http) cls = CLS_HTTP;
    else if (tls) cls = CLS_TLS;

    rep.pkt_class      = cls;
    rep.vlan_seen      = vlan_tag_seen;
    rep.ipv4_seen      = has_v4;
    rep.ipv6_seen      = has_v6;
    rep.tcp_seen       = has_tcp;
    rep.udp_seen       = has_udp;
    rep.l3_protocol    = proto_q;
    rep.l4_header_len  = l4h;
    rep.payload_offset = 16'(poff);
    rep.payload_len    = 16'(plen);
    rep.header_ok      = !(bad_hdr || trunc);
    pending_reports.push_back(rep);
    clear_parse_state();
  endtask

  // Send one word: optionally idle first, then hold valid and the payload
  // until the block takes the word. Handshake signals are sampled at the
  // edge, before the block's own updates of that edge land.
  task automatic send_word(input logic [7:0] d, input logic is_last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= is_last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    track_header_byte(d, is_last);
  endtask

  // Build one frame: MACs, up to two tags, ethertype, an IP header with the
  // given version and IHL, an L4 header, payload led by the four bytes in
  // head, then cut it to cut words when cut is nonzero.
  task automatic send_frame(input int tags, input logic [15:0] etype, input logic [3:0] ver,
                            input logic [3:0] ihl, input logic [7:0] proto,
                            input logic [3:0] doff, input logic [31:0] head,
                            input int pay_bytes, input int cut);
    logic [7:0] fr[$];
    int         hl;
    logic       is_ip;
    is_ip = (etype == ETYPE_IPV4 || etype == ETYPE_IPV6) && tags < 2;
    repeat (12) fr.push_back(8'($urandom));
    for (int t = 0; t < tags; t++) begin
      fr.push_back(ETYPE_VLAN[15:8]);
      fr.push_back(ETYPE_VLAN[7:0]);
      fr.push_back(8'($urandom));
      fr.push_back(8'($urandom));
    end
    fr.push_back(etype[15:8]);
    fr.push_back(etype[7:0]);
    if (etype == ETYPE_IPV4) begin
      hl = (ihl < MIN_HDR_WORDS) ? IPV4_BASE_HDR : 4 * ihl;
      for (int i = 0; i < hl; i++)
        fr.push_back(i == 0 ? {ver, ihl} : i == IPV4_PROTO_OFS ? proto : 8'($urandom));
    end else if (etype == ETYPE_IPV6) begin
      for (int i = 0; i < IPV6_BASE_HDR; i++)
        fr.push_back(i == 0 ? {ver, 4'($urandom)} : i == IPV6_NH_OFS ? proto : 8'($urandom));
    end else begin
      repeat ($urandom_range(0, 6)) fr.push_back(8'($urandom));
    end
    if (is_ip) begin
      if (proto == PROTO_TCP) begin
        hl = (doff < MIN_HDR_WORDS) ? TCP_BASE_HDR : 4 * doff;
        for (int i = 0; i < hl; i++)
          fr.push_back(i == TCP_DOFF_OFS ? {doff, 4'($urandom)} : 8'($urandom));
      end else if (proto == PROTO_UDP || proto == PROTO_ICMP) begin
        repeat (8) fr.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 8)) fr.push_back(8'($urandom));
      end
    end
    for (int i = 0; i < pay_bytes; i++)
      fr.push_back(i < 4 ? head[31 - 8 * i -: 8] : 8'($urandom));
    if (cut > 0) while (fr.size() > cut) fr.pop_back();
    foreach (fr[i]) send_word(fr[i], i == fr.size() - 1);
  endtask

  // Frames that carry no IP header bytes.
  task automatic test_non_ip();
    send_frame(0, 16'h1234, 4'h0, 4'h0, 8'h00, 4'h0, '0, 0, 1);   // single-word frame
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd5, '0, 0, 13);
    send_frame(0, 16'hFFFF, 4'h0, 4'h0, 8'h00, 4'h0, '0, 0, 0);
    send_frame(0, 16'h0000, 4'h0, 4'h0, 8'h00, 4'h0, '0, 3, 0);
  endtask

  // IPv4 and IPv6 with L4 protocols that are neither TCP nor UDP.
  task automatic test_ip_layers();
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, 8'd50, 4'd0, $urandom, 6, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd15, 8'hFF, 4'd0, $urandom, 2, 0);
    send_frame(0, ETYPE_IPV6, IPV6_VERSION, 4'd0, 8'd59, 4'd0, $urandom, 0, 0);
    send_frame(0, ETYPE_IPV6, IPV6_VERSION, 4'd0, 8'd0, 4'd0, $urandom, 5, 0);
  endtask

  task automatic test_transport();
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd5, $urandom, 10, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd7, PROTO_TCP, 4'd15, $urandom, 0, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_UDP, 4'd0, $urandom, 5, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_ICMP, 4'd0, $urandom, 4, 0);
    send_frame(0, ETYPE_IPV6, IPV6_VERSION, 4'd0, PROTO_TCP, 4'd8, $urandom, 4, 0);
    send_frame(0, ETYPE_IPV6, IPV6_VERSION, 4'd0, PROTO_UDP, 4'd0, $urandom, 0, 0);
  endtask

  // One tag shifts L3 by four; a second tag leaves the frame as VLAN only.
  task automatic test_vlan_tags();
    send_frame(1, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_UDP, 4'd0, $urandom, 6, 0);
    send_frame(1, ETYPE_IPV6, IPV6_VERSION, 4'd0, PROTO_TCP, 4'd5, $urandom, 2, 0);
    send_frame(2, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd5, '0, 0, 0);
    send_frame(1, 16'h88CC, 4'd0, 4'd0, 8'd0, 4'd0, '0, 0, 0);
    send_frame(1, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd5, '0, 0, 16);
  endtask

  task automatic test_app_signatures();
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd5, HTTP_GET, 8, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd6, PROTO_TCP, 4'd6, HTTP_POST, 4, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_UDP, 4'd0, HTTP_PUT, 20, 0);
    send_frame(0, ETYPE_IPV6, IPV6_VERSION, 4'd0, PROTO_TCP, 4'd5, HTTP_HEAD, 6, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_UDP, 4'd0,
               {TLS_HANDSHAKE, TLS_MAJOR, 16'h0100}, 3, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd5,
               {TLS_HANDSHAKE, TLS_MAJOR, 16'h0301}, 9, 0);
    // GET cut to three bytes is no longer a method match.
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd5, HTTP_GET, 3, 0);
    send_frame(1, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd5, HTTP_GET, 4, 0);
  endtask

  task automatic test_header_errors();
    send_frame(0, ETYPE_IPV4, IPV6_VERSION, 4'd5, PROTO_UDP, 4'd0, $urandom, 2, 0);
    send_frame(0, ETYPE_IPV6, IPV4_VERSION, 4'd0, PROTO_UDP, 4'd0, $urandom, 2, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd3, PROTO_TCP, 4'd5, HTTP_GET, 6, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd0, PROTO_UDP, 4'd0, $urandom, 2, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd4, HTTP_GET, 6, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd0, $urandom, 4, 0);
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd5, '0, 0, 20);  // in IP header
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd5, '0, 0, 44);  // before offset
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_TCP, 4'd8, '0, 0, 49);  // before payload
    send_frame(0, ETYPE_IPV4, IPV4_VERSION, 4'd5, PROTO_UDP, 4'd0, '0, 0, 39);
    send_frame(0, ETYPE_IPV6, IPV6_VERSION, 4'd0, PROTO_TCP, 4'd5, '0, 0, 30);
  endtask

  // Mostly well-formed frames with random content; the rest carry bad versions,
  // short header lengths, odd ethertypes, extra tags or a cut.
  task automatic test_random_traffic(input int min_words, input int min_frames);
    int          start_words, frames, pick, tags, pay, cut;
    logic [15:0] etype;
    logic [3:0]  ver, ihl, doff;
    logic [7:0]  proto;
    logic [31:0] head;
    start_words = words_sent;
    frames = 0;
    while (words_sent - start_words < min_words || frames < min_frames) begin
      pick  = $urandom_range(99);
      tags  = (pick < 70) ? 0 : (pick < 95) ? 1 : 2;
      pick  = $urandom_range(99);
      etype = (pick < 50) ? ETYPE_IPV4 : (pick < 85) ? ETYPE_IPV6 : 16'($urandom);
      ver   = (etype == ETYPE_IPV6) ? IPV6_VERSION : IPV4_VERSION;
      if ($urandom_range(99) < 8) ver = 4'($urandom);
      ihl   = ($urandom_range(99) < 70) ? MIN_HDR_WORDS : 4'($urandom);
      doff  = ($urandom_range(99) < 70) ? MIN_HDR_WORDS : 4'($urandom);
      pick  = $urandom_range(99);
      proto = (pick < 45) ? PROTO_TCP : (pick < 75) ? PROTO_UDP :
              (pick < 85) ? PROTO_ICMP : 8'($urandom);
      case ($urandom_range(9))
        0:       head = HTTP_GET;
        1:       head = HTTP_POST;
        2:       head = HTTP_PUT;
        3:       head = HTTP_HEAD;
        4, 5:    head = {TLS_HANDSHAKE, TLS_MAJOR, 16'($urandom)};
        default: head = $urandom;
      endcase
      pay = ($urandom_range(99) < 80) ? $urandom_range(0, 12) : $urandom_range(0, 200);
      cut = ($urandom_range(99) < 15) ? $urandom_range(1, 80) : 0;
      send_frame(tags, etype, ver, ihl, proto, doff, head, pay, cut);
      frames++;
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Drop stall bits onto out_ready every cycle at the phase's rate.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Compare every accepted report with the oldest one owed.
  always @(posedge clk) begin : report_check
    php_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: report with no frame owed, class %0d", $time, out_pkt_class);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("pkt_class", want.pkt_class, out_pkt_class);
        check_field("vlan_seen", want.vlan_seen, out_vlan_seen);
        check_field("ipv4_seen", want.ipv4_seen, out_ipv4_seen);
        check_field("ipv6_seen", want.ipv6_seen, out_ipv6_seen);
        check_field("tcp_seen", want.tcp_seen, out_tcp_seen);
        check_field("udp_seen", want.udp_seen, out_udp_seen);
        check_field("l3_protocol", want.l3_protocol, out_l3_protocol);
        check_field("l4_header_len", want.l4_header_len, out_l4_header_len);
        check_field("payload_offset", want.payload_offset, out_payload_offset);
        check_field("payload_len", want.payload_len, out_payload_len);
        check_field("header_ok", want.header_ok, out_header_ok);
      end
    end
  end

  // Watchdog: end the run when neither side moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d reports owed", $time, QUIET_LIMIT,
               pending_reports.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_parse_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames spread over the idling phases, each phase closed by a
    // short run of random traffic.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_non_ip();
    test_ip_layers();
    test_random_traffic(30, 1);

    send_idle_pct = 78;
    test_transport();
    test_vlan_tags();
    test_random_traffic(30, 1);

    send_idle_pct  = 0;
    recv_stall_pct = 78;
    test_app_signatures();
    test_random_traffic(30, 1);

    send_idle_pct  = 26;
    recv_stall_pct = 26;
    test_header_errors();
    test_random_traffic(30, 1);

    // Drain: wait for every owed report, then a further wait of DRAIN_CYCLES for strays.
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
design/php_pkg.sv
design/php_parse.sv
design/php_report.sv
design/packet_header_parser_classifier.sv
tb/sv/tb_top.sv
